// File: rtl/core/cdm_pkg.sv
package cdm_pkg;

	// Fixed widths of the payload fields.
	localparam int SAMPLE_W = 16;
	localparam int DISK_W   = 16;

	// Offsets 2u-1 in Q1.16 take 18 signed bits; their magnitudes take 17.
	localparam int OFS_W = SAMPLE_W + 2;
	localparam int MAG_W = SAMPLE_W + 1;
	localparam logic signed [OFS_W-1:0] OFS_BIAS = 18'sd65536;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// pi/4, the limit CORDIC gain 1/K and atan(2^-i) for i = 0..10, all in Q.32.
	localparam logic [31:0] PI4_Q32  = 32'd3373259426;
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
	localparam logic [31:0] ATAN_Q32 [0:10] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748, 32'd134174063, 32'd67103403, 32'd33553749,
		32'd16777131, 32'd8388597, 32'd4194303
	};

	// Sideband that travels with every item down the pipeline.
	typedef struct packed {
		logic [MAG_W-1:0] rmag;
		logic             rneg;
		logic             swap;
		logic             pneg;
		logic             zero;
	} side_t;

	// Rounds a Q.32 constant to nearest at the requested fraction width.
	function automatic logic [63:0] q32_to_qf(input logic [63:0] t, input int frac);
		logic [63:0] r;
		int s;
		s = 32 - frac;
		if (s <= 0) begin
			r = t;
		end else begin
			r = (t + (64'd1 << (s - 1))) >> s;
		end
		return r;
	endfunction

	// Arctangent of 2^-i rounded to the requested fraction width.
	function automatic logic [63:0] atan_qf(input int i, input int frac);
		logic [63:0] t;
		if (i <= 10) begin
			t = 64'(ATAN_Q32[i[3:0]]);
		end else if (i <= 32) begin
			t = 64'd1 << (32 - i);
		end else begin
			t = '0;
		end
		return q32_to_qf(t, frac);
	endfunction

endpackage

// File: rtl/core/cdm_sample_if.sv
interface cdm_sample_if;
	logic                          valid;
	logic                          ready;
	logic [cdm_pkg::SAMPLE_W-1:0]  sample_u;
	logic [cdm_pkg::SAMPLE_W-1:0]  sample_v;

	modport source (output valid, output sample_u, output sample_v, input ready);
	modport sink (input valid, input sample_u, input sample_v, output ready);
endinterface

// File: rtl/core/cdm_disk_if.sv
interface cdm_disk_if;
	logic                               valid;
	logic                               ready;
	logic signed [cdm_pkg::DISK_W-1:0]  disk_x;
	logic signed [cdm_pkg::DISK_W-1:0]  disk_y;

	modport source (output valid, output disk_x, output disk_y, input ready);
	modport sink (input valid, input disk_x, input disk_y, output ready);
endinterface

// File: rtl/core/concentric_disk_map.sv
// Concentric square-to-disk mapping, fully pipelined.
// Stages from an input transfer to the result: one setup stage, one restoring-divider stage per
// quotient bit, two phase stages, one CORDIC stage per rotation, one output multiply stage and the
// output register. Throughput: one item per cycle while the output buffer is not full; a two-entry
// output buffer keeps input open while a result waits.
// Reset clears the valid bits and the output buffer count; the other registers are not reset.
module concentric_disk_map #(
	parameter int FRAC_BITS    = cdm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = cdm_pkg::CORDIC_STEPS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	cdm_sample_if.sink   samples,
	cdm_disk_if.source   points
);

	localparam int F      = FRAC_BITS;
	localparam int N      = CORDIC_STEPS;
	localparam int MAG_W  = cdm_pkg::MAG_W;
	localparam int OFS_W  = cdm_pkg::OFS_W;
	localparam int OUT_W  = cdm_pkg::DISK_W;
	localparam int DW     = MAG_W + F + 1;
	localparam int QW     = F + 1;
	localparam int PPW    = 2 * F + 1;
	localparam int CW     = F + 3;
	localparam int PW     = MAG_W + CW - 1;
	localparam int RW     = PW - F;
	localparam int K_PM   = F + 2;
	localparam int K_OM   = F + 4 + N;
	localparam int STAGES = F + N + 5;

	localparam logic [63:0] PI4_W  = cdm_pkg::q32_to_qf(64'(cdm_pkg::PI4_Q32), F);
	localparam logic [63:0] GAIN_W = cdm_pkg::q32_to_qf(64'(cdm_pkg::GAIN_Q32), F);

	localparam logic [1:0] CNT_EMPTY = 2'd0;
	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_FULL  = 2'd2;

	logic                    en;
	logic [STAGES-1:0]       vld_s;
	cdm_pkg::side_t          side_s [0:STAGES-1];

	logic [1:0]              cnt_q;
	logic signed [OUT_W-1:0] head_x_q, head_y_q, skid_x_q, skid_y_q;
	logic                    push, pop;

	// ---------------------------------------------------------------- setup
	logic signed [OFS_W-1:0] ox, oy;
	logic [OFS_W-1:0]        ax, ay;
	logic [MAG_W-1:0]        mx, my, nm, dm;
	logic                    swap, qneg;
	logic [DW-1:0]           rem_in;
	cdm_pkg::side_t          side_in;

	always_comb begin
		ox = signed'({1'b0, samples.sample_u, 1'b0}) - cdm_pkg::OFS_BIAS;
		oy = signed'({1'b0, samples.sample_v, 1'b0}) - cdm_pkg::OFS_BIAS;
		ax = ox[OFS_W-1] ? OFS_W'(-ox) : OFS_W'(ox);
		ay = oy[OFS_W-1] ? OFS_W'(-oy) : OFS_W'(oy);
		mx = ax[MAG_W-1:0];
		my = ay[MAG_W-1:0];
		// Ties go to the vertical branch.
		swap = !(mx > my);
		nm = swap ? mx : my;
		dm = swap ? my : mx;
		qneg = ox[OFS_W-1] ^ oy[OFS_W-1];
		rem_in = (DW'(nm) << F) + DW'(dm >> 1);
		side_in.rmag = swap ? my : mx;
		side_in.rneg = swap ? oy[OFS_W-1] : ox[OFS_W-1];
		side_in.swap = swap;
		side_in.pneg = swap ? !qneg : qneg;
		side_in.zero = (ox == '0) && (oy == '0);
	end

	assign en = (cnt_q != CNT_FULL);
	assign samples.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[STAGES-2:0], samples.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < STAGES; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------- divider
	logic [DW-1:0]    rem_s [0:QW];
	logic [QW-1:0]    q_s   [0:QW];
	logic [MAG_W-1:0] den_s [0:QW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem_in;
			q_s[0]   <= '0;
			den_s[0] <= dm;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_div
		localparam int B = QW - k;
		logic [DW:0] trial;

		assign trial = {1'b0, rem_s[k-1]} - ({1'b0, DW'(den_s[k-1])} << B);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= trial[DW] ? rem_s[k-1] : trial[DW-1:0];
				q_s[k]   <= {q_s[k-1][QW-2:0], !trial[DW]};
			end
		end

		if (k < QW) begin : g_den
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------- phase
	logic [PPW-1:0]       pprod_s;
	logic [PPW:0]         psum;
	logic signed [CW-1:0] zpos, z0;

	always_ff @(posedge clk) begin
		if (en) begin
			pprod_s <= PPW'(PI4_W[F-1:0]) * PPW'(q_s[QW]);
		end
	end

	always_comb begin
		psum = {1'b0, pprod_s} + ((PPW + 1)'(1) << (F - 1));
		zpos = signed'({1'b0, psum[PPW:F]});
		z0   = side_s[K_PM].pneg ? -zpos : zpos;
	end

	// ---------------------------------------------------------------- CORDIC
	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [CW-1:0] z_s [0:N];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= signed'(GAIN_W[CW-1:0]);
			y_s[0] <= '0;
			z_s[0] <= z0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic [63:0] AT64 = cdm_pkg::atan_qf(i, F);
		localparam logic signed [CW-1:0] AT = signed'(AT64[CW-1:0]);

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end
			end
		end
	end

	// ---------------------------------------------------------------- output multiply
	logic [CW-1:0]   xabs, yabs;
	logic [CW-2:0]   cxm, cym;
	logic            xneg, yneg, ypos, cxn, cyn;
	logic [PW-1:0]   pxm_s, pym_s;
	logic            pxn_s, pyn_s;
	cdm_pkg::side_t  side_om;

	always_comb begin
		side_om = side_s[K_OM-1];
		xneg = x_s[N][CW-1];
		yneg = y_s[N][CW-1];
		ypos = !yneg && (y_s[N] != '0);
		xabs = xneg ? CW'(-x_s[N]) : CW'(x_s[N]);
		yabs = yneg ? CW'(-y_s[N]) : CW'(y_s[N]);
		// The vertical branch rotates by a further quarter turn: (x, y) becomes (-y, x).
		cxm = side_om.swap ? yabs[CW-2:0] : xabs[CW-2:0];
		cxn = side_om.swap ? ypos : xneg;
		cym = side_om.swap ? xabs[CW-2:0] : yabs[CW-2:0];
		cyn = side_om.swap ? xneg : yneg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxm_s <= PW'(side_om.rmag) * PW'(cxm);
			pym_s <= PW'(side_om.rmag) * PW'(cym);
			pxn_s <= side_om.rneg ^ cxn;
			pyn_s <= side_om.rneg ^ cyn;
		end
	end

	// ---------------------------------------------------------------- round and saturate
	function automatic logic [OUT_W-1:0] sat_q15(input logic [RW-1:0] m, input logic neg);
		logic [OUT_W-1:0] r;
		if (neg) begin
			r = (m >= RW'(32768)) ? 16'h8000 : OUT_W'(~m[OUT_W-1:0] + 16'd1);
		end else begin
			r = (m >= RW'(32767)) ? 16'h7fff : m[OUT_W-1:0];
		end
		return r;
	endfunction

	logic [PW:0]             rsx, rsy;
	logic signed [OUT_W-1:0] res_x, res_y;

	always_comb begin
		rsx = {1'b0, pxm_s} + ((PW + 1)'(1) << F);
		rsy = {1'b0, pym_s} + ((PW + 1)'(1) << F);
		if (side_s[K_OM].zero) begin
			res_x = '0;
			res_y = '0;
		end else begin
			res_x = signed'(sat_q15(rsx[PW:F+1], pxn_s));
			res_y = signed'(sat_q15(rsy[PW:F+1], pyn_s));
		end
	end

	// ---------------------------------------------------------------- output buffer
	assign push = en && vld_s[STAGES-1];
	assign pop  = points.valid && points.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_EMPTY;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		priority if (push && (cnt_q == CNT_EMPTY || pop)) begin
			head_x_q <= res_x;
			head_y_q <= res_y;
		end else if (push) begin
			skid_x_q <= res_x;
			skid_y_q <= res_y;
		end else if (pop && cnt_q == CNT_FULL) begin
			head_x_q <= skid_x_q;
			head_y_q <= skid_y_q;
		end
	end

	// A full buffer can only be reached from one entry with a push and no pop.
	assign points.valid  = (cnt_q != CNT_EMPTY);
	assign points.disk_x = head_x_q;
	assign points.disk_y = head_y_q;

`ifndef SYNTHESIS
	// Items in flight change only by transfers at the two ends.
	a_item_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_s) + int'(cnt_q)) ==
			($past($countones(vld_s) + int'(cnt_q))
			+ int'($past(samples.valid && samples.ready))
			- int'($past(points.valid && points.ready))))
		else $error("item count in pipeline and output buffer is not conserved");

	// A stalled last stage keeps its item and its products.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[STAGES-1] && !en) |=> (vld_s[STAGES-1] && $stable(pxm_s) && $stable(pym_s)))
		else $error("stalled output multiply stage changed");

	// The buffer never overflows: a full buffer is only left by a pop.
	a_buffer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CNT_FULL) |=> (cnt_q == CNT_FULL || cnt_q == CNT_ONE))
		else $error("output buffer count out of range");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int SAMPLE_W   = cdm_pkg::SAMPLE_W;
	localparam int DISK_W     = cdm_pkg::DISK_W;

	localparam int FRAC       = 16;
	localparam int STEPS      = 16;
	localparam int LATENCY    = FRAC + STEPS + 6;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTS = 40;

	// atan(2^-i) in Q.32 for the first eleven rotations; later ones are 2^(32-i).
	localparam longint unsigned ATAN_TBL [0:10] = '{
		64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
		64'd268086748, 64'd134174063, 64'd67103403, 64'd33553749,
		64'd16777131, 64'd8388597, 64'd4194303
	};
	localparam longint unsigned QUARTER_PI_Q32 = 64'd3373259426;
	localparam longint unsigned INV_GAIN_Q32   = 64'd2608131496;

	typedef struct {
		logic [SAMPLE_W-1:0]        u;
		logic [SAMPLE_W-1:0]        v;
		logic signed [DISK_W-1:0]   x;
		logic signed [DISK_W-1:0]   y;
	} disk_point_t;

	logic clk;
	logic arst_n;

	cdm_sample_if samples_if ();
	cdm_disk_if   points_if ();

	concentric_disk_map #(
		.FRAC_BITS   (FRAC),
		.CORDIC_STEPS(STEPS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.points (points_if)
	);

	disk_point_t pending_points[$];
	int n_sent;
	int n_checked;
	int n_errors;
	int n_ties;
	int n_origin;
	int src_idle_pct;
	int sink_idle_pct;
	int hold_request;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned abs64(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned round_down_bits(input longint unsigned m, input int s);
		if (s <= 0)
			return m;
		return (m + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic longint unsigned arctan_qf(input int i);
		longint unsigned t;
		if (i <= 10)
			t = ATAN_TBL[i];
		else if (i <= 32)
			t = 64'd1 << (32 - i);
		else
			t = 0;
		return round_down_bits(t, 32 - FRAC);
	endfunction

	// Radius times a Q.F coordinate, taken to Q1.15 with round-half-away and clamped.
	function automatic logic signed [DISK_W-1:0] scale_to_q15(input longint r, input longint c);
		longint unsigned m;
		longint v;
		bit neg;
		neg = (r < 0) != (c < 0);
		m = round_down_bits(abs64(r) * abs64(c), FRAC + 1);
		v = neg ? -longint'(m) : longint'(m);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[DISK_W-1:0];
	endfunction

	function automatic disk_point_t map_to_disk(input logic [SAMPLE_W-1:0] u,
			input logic [SAMPLE_W-1:0] v);
		disk_point_t p;
		longint ox, oy, r, num, den, phi, cx, cy, cz, dx, dy;
		longint unsigned qm, pm;
		bit qneg, swap;
		p.u = u;
		p.v = v;
		ox = 2 * longint'(u) - 65536;
		oy = 2 * longint'(v) - 65536;
		if (ox == 0 && oy == 0) begin
			p.x = '0;
			p.y = '0;
			return p;
		end
		swap = !(abs64(ox) > abs64(oy));
		if (!swap) begin
			r = ox; num = oy; den = ox;
		end else begin
			r = oy; num = ox; den = oy;
		end
		qm = ((abs64(num) << FRAC) + abs64(den) / 2) / abs64(den);
		qneg = (num < 0) != (den < 0);
		pm = round_down_bits(round_down_bits(QUARTER_PI_Q32, 32 - FRAC) * qm, FRAC);
		phi = (swap ? !qneg : qneg) ? -longint'(pm) : longint'(pm);

		cx = longint'(round_down_bits(INV_GAIN_Q32, 32 - FRAC));
		cy = 0;
		cz = phi;
		for (int i = 0; i < STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cz >= 0) begin
				cx -= dx; cy += dy; cz -= longint'(arctan_qf(i));
			end else begin
				cx += dx; cy -= dy; cz += longint'(arctan_qf(i));
			end
		end

		// The second branch rotates by a further quarter turn, done as a swap.
		if (!swap) begin
			p.x = scale_to_q15(r, cx);
			p.y = scale_to_q15(r, cy);
		end else begin
			p.x = scale_to_q15(r, -cy);
			p.y = scale_to_q15(r, cx);
		end
		return p;
	endfunction

	task automatic report_mismatch(input string what);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] u, input logic [SAMPLE_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid    <= 1'b1;
		samples_if.sample_u <= u;
		samples_if.sample_v <= v;
		do
			@(posedge clk);
		while (!samples_if.ready);
		pending_points.insert(pending_points.size(), map_to_disk(u, v));
		n_sent++;
		if (u == v || 32'(u) + 32'(v) == 65536)
			n_ties++;
		if (u == 16'h8000 && v == 16'h8000)
			n_origin++;
	endtask

	// Stops offering, waits for every expected point, then lets the pipeline run dry.
	task automatic settle();
		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic random_pair(output logic [SAMPLE_W-1:0] u, output logic [SAMPLE_W-1:0] v);
		int kind;
		kind = $urandom_range(99);
		u = 16'($urandom_range(65535));
		v = 16'($urandom_range(65535));
		if (kind < 55) begin
			// plain uniform pairs
		end else if (kind < 65) begin
			v = u;
		end else if (kind < 75) begin
			v = 16'($urandom_range(65535, 1));
			u = 16'(65536 - 32'(v));
		end else if (kind < 85) begin
			u = 16'h8000 + 16'($signed($urandom_range(16)) - 8);
			v = 16'h8000 + 16'($signed($urandom_range(16)) - 8);
		end else if (kind < 95) begin
			u = 16'($urandom_range(1) ? $urandom_range(3) : $urandom_range(65535, 65532));
			v = 16'($urandom_range(1) ? $urandom_range(3) : $urandom_range(65535, 65532));
		end else if ($urandom_range(1)) begin
			u = 16'h8000;
		end else begin
			v = 16'h8000;
		end
	endtask

	task automatic test_directed();
		logic [SAMPLE_W-1:0] us [$];
		logic [SAMPLE_W-1:0] vs [$];
		us = '{16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0000,
			16'h8000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h8001, 16'h8001, 16'h8000,
			16'h9C40, 16'h0001, 16'h7FFF, 16'h5555, 16'hAAAA};
		vs = '{16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000,
			16'hFFFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001,
			16'h7530, 16'h0001, 16'h7FFF, 16'hAAAA, 16'h5555};
		foreach (us[i])
			send_sample(us[i], vs[i]);
		settle();
	endtask

	task automatic test_random_phase(input int count, input int src_pct, input int sink_pct);
		logic [SAMPLE_W-1:0] u;
		logic [SAMPLE_W-1:0] v;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (count) begin
			random_pair(u, v);
			send_sample(u, v);
		end
		settle();
	endtask

	// The output is held off long enough that the pipeline fills and input backs up.
	task automatic test_output_stall();
		logic [SAMPLE_W-1:0] u;
		logic [SAMPLE_W-1:0] v;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_request  = 250;
		repeat (150) begin
			random_pair(u, v);
			send_sample(u, v);
		end
		settle();
	endtask

	task automatic test_drain_pause();
		logic [SAMPLE_W-1:0] u;
		logic [SAMPLE_W-1:0] v;
		src_idle_pct  = 10;
		sink_idle_pct = 20;
		repeat (40) begin
			random_pair(u, v);
			send_sample(u, v);
		end
		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (40) begin
			random_pair(u, v);
			send_sample(u, v);
		end
		settle();
	endtask

	initial begin
		points_if.ready = 1'b0;
		forever begin
			int hold_left;
			@(negedge clk);
			if (hold_left > 0) begin
				points_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_request > 0) begin
				hold_left = hold_request - 1;
				hold_request = 0;
				points_if.ready <= 1'b0;
			end else begin
				points_if.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		disk_point_t want;
		if (arst_n && points_if.valid && points_if.ready) begin
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point (%0d, %0d)",
					points_if.disk_x, points_if.disk_y));
			end else begin
				want = pending_points.pop_front();
				n_checked++;
				if (points_if.disk_x !== want.x)
					report_mismatch($sformatf("u=%h v=%h disk_x got %0d want %0d",
						want.u, want.v, points_if.disk_x, want.x));
				if (points_if.disk_y !== want.y)
					report_mismatch($sformatf("u=%h v=%h disk_y got %0d want %0d",
						want.u, want.v, points_if.disk_y, want.y));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (samples_if.valid && samples_if.ready) ||
				(points_if.valid && points_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d cycles without a transfer", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		samples_if.valid    = 1'b0;
		samples_if.sample_u = '0;
		samples_if.sample_v = '0;
		n_sent = 0;
		n_checked = 0;
		n_errors = 0;
		n_ties = 0;
		n_origin = 0;
		src_idle_pct = 6;
		sink_idle_pct = 49;
		hold_request = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(380, 6, 49);
		test_random_phase(380, 49, 6);
		test_random_phase(380, 0, 0);
		test_output_stall();
		test_drain_pause();

		$display("Sent %0d sample pairs (%0d equal-magnitude, %0d at the center) under", n_sent,
			n_ties, n_origin);
		$display("  random idling on both sides, a long output stall and a full drain; %0d checked.",
			n_checked);
		if (n_errors == 0 && pending_points.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d points never arrived", n_errors, pending_points.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
